@@ src/satd_pkg.sv @@
// Package for the slot aging tier demoter: field widths, codes and types
// shared by satd_age_mem, satd_ctrl and slot_aging_tier_demoter_top.
// No dependencies.
package satd_pkg;

  // Field widths
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned AGE_W     = 8;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned NEXT_W    = 6;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Default table size
  localparam int unsigned SLOTS_DEFAULT = 32;

  // Saturation limits and reset thresholds
  localparam logic [AGE_W-1:0] AGE_MAX        = '1;
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [CFG_W-1:0] MEM_ROUNDS_RST = 8'd4;
  localparam logic [CFG_W-1:0] DSK_ROUNDS_RST = 8'd16;

  // Transaction opcodes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 2'd0,
    ACT_USE  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_TICK = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEMORY_ROUNDS = 1'b0,
    CFG_DISK_ROUNDS   = 1'b1
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP_RD,
    ST_SWEEP_CHK,
    ST_FINAL
  } state_e;

  // Age memory access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } age_ctl_t;

endpackage

@@ src/satd_age_mem.sv @@
// Idle-age memory: one write port, one read port, registered read data.
// Depends on satd_pkg.
module satd_age_mem #(
  parameter int unsigned SLOTS = satd_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk_i,
  input  satd_pkg::age_ctl_t            ctl_i,
  input  logic [$clog2(SLOTS)-1:0]      rd_addr_i,
  input  logic [$clog2(SLOTS)-1:0]      wr_addr_i,
  input  logic [satd_pkg::AGE_W-1:0]    wr_data_i,
  output logic [satd_pkg::AGE_W-1:0]    rd_data_o
);

  logic [satd_pkg::AGE_W-1:0] mem_q [SLOTS];

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ src/satd_ctrl.sv @@
// Controller: valid bits, allocation pointer, use counter, thresholds,
// sweep sequencer and result register. Drives satd_age_mem. Depends on satd_pkg.
module satd_ctrl #(
  parameter int unsigned SLOTS = satd_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [satd_pkg::ACT_W-1:0]      action_i,
  input  logic [satd_pkg::SLOT_W-1:0]     slot_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [satd_pkg::SLOT_W-1:0]     slot_out_o,
  output logic [satd_pkg::STAT_W-1:0]     status_o,
  output logic                            to_memory_o,
  output logic                            to_disk_o,
  output logic [satd_pkg::CNT_W-1:0]      use_total_o,
  output logic                            last_o,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [satd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [satd_pkg::CFG_W-1:0]      cfg_data_i,
  // age memory
  output satd_pkg::age_ctl_t              age_ctl_o,
  output logic [$clog2(SLOTS)-1:0]        age_rd_addr_o,
  output logic [$clog2(SLOTS)-1:0]        age_wr_addr_o,
  output logic [satd_pkg::AGE_W-1:0]      age_wr_data_o,
  input  logic [satd_pkg::AGE_W-1:0]      age_rd_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam logic [satd_pkg::NEXT_W-1:0] SLOTS_N  = satd_pkg::NEXT_W'(SLOTS);
  localparam logic [IDX_W-1:0]            LAST_IDX = IDX_W'(SLOTS - 1);

  satd_pkg::state_e state_q, state_d;

  satd_pkg::action_e                act_q, act_d;
  logic [satd_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic [SLOTS-1:0]                 valid_q, valid_d;
  logic [satd_pkg::NEXT_W-1:0]      next_slot_q, next_slot_d;
  logic [satd_pkg::CNT_W-1:0]       use_cnt_q, use_cnt_d;
  logic [IDX_W-1:0]                 sweep_idx_q, sweep_idx_d;
  logic [satd_pkg::CFG_W-1:0]       mem_rounds_q, mem_rounds_d;
  logic [satd_pkg::CFG_W-1:0]       dsk_rounds_q, dsk_rounds_d;

  // result register
  logic                             out_valid_q, out_valid_d;
  logic [satd_pkg::SLOT_W-1:0]      res_slot_q, res_slot_d;
  satd_pkg::status_e                res_stat_q, res_stat_d;
  logic                             res_mem_q, res_mem_d;
  logic                             res_dsk_q, res_dsk_d;
  logic [satd_pkg::CNT_W-1:0]       res_total_q, res_total_d;
  logic                             res_last_q, res_last_d;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic [IDX_W-1:0] sidx;
  logic             present;
  logic             full;
  logic             age_hit;
  logic             sweep_step;

  assign in_acc   = in_valid_i && (state_q == satd_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign sidx     = IDX_W'(slot_q);
  assign present  = (satd_pkg::NEXT_W'(slot_q) < SLOTS_N) && valid_q[sidx];
  assign full     = (next_slot_q >= SLOTS_N);
  assign age_hit  = (age_rd_data_i >= mem_rounds_q);
  // a checked slot retires once its demote result (if any) has a place to go
  assign sweep_step = !age_hit || out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      satd_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (satd_pkg::action_e'(action_i) == satd_pkg::ACT_TICK)
                    ? satd_pkg::ST_SWEEP_RD : satd_pkg::ST_EXEC;
        end
      end
      satd_pkg::ST_EXEC: begin
        if (out_free) state_d = satd_pkg::ST_IDLE;
      end
      satd_pkg::ST_SWEEP_RD: begin
        if (valid_q[sweep_idx_q]) state_d = satd_pkg::ST_SWEEP_CHK;
        else if (sweep_idx_q == LAST_IDX) state_d = satd_pkg::ST_FINAL;
      end
      satd_pkg::ST_SWEEP_CHK: begin
        if (sweep_step) begin
          state_d = (sweep_idx_q == LAST_IDX) ? satd_pkg::ST_FINAL
                                              : satd_pkg::ST_SWEEP_RD;
        end
      end
      satd_pkg::ST_FINAL: begin
        if (out_free) state_d = satd_pkg::ST_IDLE;
      end
      default: state_d = satd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    act_d         = act_q;
    slot_d        = slot_q;
    valid_d       = valid_q;
    next_slot_d   = next_slot_q;
    use_cnt_d     = use_cnt_q;
    sweep_idx_d   = sweep_idx_q;
    mem_rounds_d  = mem_rounds_q;
    dsk_rounds_d  = dsk_rounds_q;
    age_ctl_o     = '0;
    age_rd_addr_o = sweep_idx_q;
    age_wr_addr_o = sweep_idx_q;
    age_wr_data_o = '0;
    out_load      = 1'b0;
    res_slot_d    = res_slot_q;
    res_stat_d    = res_stat_q;
    res_mem_d     = res_mem_q;
    res_dsk_d     = res_dsk_q;
    res_total_d   = res_total_q;
    res_last_d    = res_last_q;

    // thresholds (the user must write them only while idle; not enforced here)
    if (cfg_we_i) begin
      unique case (satd_pkg::cfg_idx_e'(cfg_idx_i))
        satd_pkg::CFG_MEMORY_ROUNDS: mem_rounds_d = cfg_data_i;
        satd_pkg::CFG_DISK_ROUNDS:   dsk_rounds_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      satd_pkg::ST_IDLE: begin
        if (in_acc) begin
          act_d       = satd_pkg::action_e'(action_i);
          slot_d      = slot_i;
          sweep_idx_d = '0;
        end
      end

      // single-slot transactions: no age read needed
      satd_pkg::ST_EXEC: begin
        if (out_free) begin
          out_load    = 1'b1;
          res_slot_d  = slot_q;
          res_stat_d  = satd_pkg::STAT_OK;
          res_mem_d   = 1'b0;
          res_dsk_d   = 1'b0;
          res_total_d = '0;
          res_last_d  = 1'b1;
          unique case (act_q)
            satd_pkg::ACT_ADD: begin
              if (full) begin
                res_slot_d = '0;
                res_stat_d = satd_pkg::STAT_FULL;
              end else begin
                valid_d[next_slot_q[IDX_W-1:0]] = 1'b1;
                age_ctl_o.wr_en = 1'b1;
                age_wr_addr_o   = next_slot_q[IDX_W-1:0];
                age_wr_data_o   = '0;
                next_slot_d     = next_slot_q + 1'b1;
                res_slot_d      = satd_pkg::SLOT_W'(next_slot_q);
              end
            end
            satd_pkg::ACT_USE: begin
              if (present) begin
                age_ctl_o.wr_en = 1'b1;
                age_wr_addr_o   = sidx;
                age_wr_data_o   = '0;
                if (use_cnt_q != satd_pkg::CNT_MAX) use_cnt_d = use_cnt_q + 1'b1;
              end else begin
                res_stat_d = satd_pkg::STAT_ABSENT;
              end
            end
            satd_pkg::ACT_DEL: begin
              if (present) valid_d[sidx] = 1'b0;
              else res_stat_d = satd_pkg::STAT_ABSENT;
            end
            satd_pkg::ACT_TICK: ;
            default: ;
          endcase
        end
      end

      // sweep: read the age of a valid slot, skip an empty one
      satd_pkg::ST_SWEEP_RD: begin
        if (valid_q[sweep_idx_q]) begin
          age_ctl_o.rd_en = 1'b1;
        end else if (sweep_idx_q != LAST_IDX) begin
          sweep_idx_d = sweep_idx_q + 1'b1;
        end
      end

      // sweep: demote check and saturating age write-back
      satd_pkg::ST_SWEEP_CHK: begin
        if (sweep_step) begin
          age_ctl_o.wr_en = 1'b1;
          age_wr_data_o   = (age_rd_data_i == satd_pkg::AGE_MAX)
                            ? age_rd_data_i : age_rd_data_i + 1'b1;
          if (sweep_idx_q != LAST_IDX) sweep_idx_d = sweep_idx_q + 1'b1;
          if (age_hit) begin
            out_load    = 1'b1;
            res_slot_d  = satd_pkg::SLOT_W'(sweep_idx_q);
            res_stat_d  = satd_pkg::STAT_OK;
            res_mem_d   = 1'b1;
            res_dsk_d   = (age_rd_data_i >= dsk_rounds_q);
            res_total_d = '0;
            res_last_d  = 1'b0;
          end
        end
      end

      // closing result with the use count
      satd_pkg::ST_FINAL: begin
        if (out_free) begin
          out_load    = 1'b1;
          res_slot_d  = '0;
          res_stat_d  = satd_pkg::STAT_OK;
          res_mem_d   = 1'b0;
          res_dsk_d   = 1'b0;
          res_total_d = use_cnt_q;
          res_last_d  = 1'b1;
          use_cnt_d   = '0;
        end
      end

      default: ;
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= satd_pkg::ST_IDLE;
      valid_q      <= '0;
      next_slot_q  <= '0;
      use_cnt_q    <= '0;
      sweep_idx_q  <= '0;
      mem_rounds_q <= satd_pkg::MEM_ROUNDS_RST;
      dsk_rounds_q <= satd_pkg::DSK_ROUNDS_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      next_slot_q  <= next_slot_d;
      use_cnt_q    <= use_cnt_d;
      sweep_idx_q  <= sweep_idx_d;
      mem_rounds_q <= mem_rounds_d;
      dsk_rounds_q <= dsk_rounds_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    slot_q      <= slot_d;
    res_slot_q  <= res_slot_d;
    res_stat_q  <= res_stat_d;
    res_mem_q   <= res_mem_d;
    res_dsk_q   <= res_dsk_d;
    res_total_q <= res_total_d;
    res_last_q  <= res_last_d;
  end

  assign in_stall_o  = (state_q != satd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_out_o  = res_slot_q;
  assign status_o    = res_stat_q;
  assign to_memory_o = res_mem_q;
  assign to_disk_o   = res_dsk_q;
  assign use_total_o = res_total_q;
  assign last_o      = res_last_q;

endmodule

@@ src/slot_aging_tier_demoter_top.sv @@
// Slot aging tier demoter: one transaction at a time. Add, use and delete
// go through an accept state, then an update state that loads the result,
// waiting while the result register holds a stalled result (out_stall_i).
// A tick walks the slot table: an empty slot is skipped, a valid one gets an
// age memory read, then compare and write-back through the single age memory,
// and a closing result follows; demote and closing results also wait on
// output stalls. A finished result waits in an output register while the next
// transaction is accepted. The user must write thresholds only while the block
// is idle; the block itself does not enforce this.
// Top level; depends on satd_pkg, satd_age_mem and satd_ctrl.
module slot_aging_tier_demoter_top #(
  parameter int unsigned SLOTS = satd_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [satd_pkg::ACT_W-1:0]      action_i,
  input  logic [satd_pkg::SLOT_W-1:0]     slot_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [satd_pkg::SLOT_W-1:0]     slot_out_o,
  output logic [satd_pkg::STAT_W-1:0]     status_o,
  output logic                            to_memory_o,
  output logic                            to_disk_o,
  output logic [satd_pkg::CNT_W-1:0]      use_total_o,
  output logic                            last_o,
  input  logic                            cfg_we_i,
  input  logic [satd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [satd_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  satd_pkg::age_ctl_t           age_ctl;
  logic [IDX_W-1:0]             age_rd_addr;
  logic [IDX_W-1:0]             age_wr_addr;
  logic [satd_pkg::AGE_W-1:0]   age_wr_data;
  logic [satd_pkg::AGE_W-1:0]   age_rd_data;

  satd_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .slot_out_o    (slot_out_o),
    .status_o      (status_o),
    .to_memory_o   (to_memory_o),
    .to_disk_o     (to_disk_o),
    .use_total_o   (use_total_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .age_ctl_o     (age_ctl),
    .age_rd_addr_o (age_rd_addr),
    .age_wr_addr_o (age_wr_addr),
    .age_wr_data_o (age_wr_data),
    .age_rd_data_i (age_rd_data)
  );

  satd_age_mem #(
    .SLOTS (SLOTS)
  ) u_age_mem (
    .clk_i     (clk_i),
    .ctl_i     (age_ctl),
    .rd_addr_i (age_rd_addr),
    .wr_addr_i (age_wr_addr),
    .wr_data_i (age_wr_data),
    .rd_data_o (age_rd_data)
  );

  // one transaction in flight: an accept is always followed by a busy cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted back to back");

  // the age memory never reads and writes in the same cycle
  a_age_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(age_ctl.rd_en && age_ctl.wr_en))
    else $error("age memory read and write overlap");

  // demote results are never final and always carry ok status
  a_demote_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && to_memory_o) |->
      (!last_o && status_o == satd_pkg::STAT_OK && use_total_o == '0))
    else $error("malformed demote result");

  // disk move only comes with a demote; results that are not demotes close the item
  a_disk_needs_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!to_disk_o || to_memory_o) && (to_memory_o || last_o)))
    else $error("disk flag or last flag inconsistent");

endmodule

@@ verif/slot_aging_tier_demoter_top_tb.sv @@
// Self-checking testbench for slot_aging_tier_demoter_top: a queue-fed driver,
// a clocked monitor and an in-bench slot table model that predicts each result.
// Depends on satd_pkg and the slot_aging_tier_demoter_top RTL.
module slot_aging_tier_demoter_top_tb;

  localparam int unsigned NSLOTS        = satd_pkg::SLOTS_DEFAULT;
  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned LIMIT_CYCLES  = 1_500_000;
  localparam int unsigned MAX_REPORTS   = 40;

  // One input transaction
  typedef struct {
    satd_pkg::action_e           act;
    logic [satd_pkg::SLOT_W-1:0] slot;
  } slot_op_t;

  // One result transaction
  typedef struct {
    logic [satd_pkg::SLOT_W-1:0] slot;
    satd_pkg::status_e           status;
    logic                        to_mem;
    logic                        to_disk;
    logic [satd_pkg::CNT_W-1:0]  total;
    logic                        last;
  } tier_result_t;

  // DUT signals
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [satd_pkg::ACT_W-1:0]     action_i    = '0;
  logic [satd_pkg::SLOT_W-1:0]    slot_i      = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [satd_pkg::SLOT_W-1:0]    slot_out_o;
  logic [satd_pkg::STAT_W-1:0]    status_o;
  logic                           to_memory_o;
  logic                           to_disk_o;
  logic [satd_pkg::CNT_W-1:0]     use_total_o;
  logic                           last_o;
  logic                           cfg_we_i    = 1'b0;
  logic [satd_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [satd_pkg::CFG_W-1:0]     cfg_data_i  = '0;

  // Bench state
  slot_op_t     pending_ops[$];
  tier_result_t awaited_results[$];
  int unsigned  mismatches    = 0;
  int unsigned  sender_idle   = 0;
  int unsigned  receiver_busy = 0;
  int unsigned  hold_left     = 0;
  logic         in_taken      = 1'b0;

  // Slot table model
  logic                        live[NSLOTS];
  logic [satd_pkg::AGE_W-1:0]  idle_age[NSLOTS];
  logic [satd_pkg::NEXT_W-1:0] alloc_ptr   = '0;
  logic [satd_pkg::CNT_W-1:0]  use_tally   = '0;
  logic [satd_pkg::CFG_W-1:0]  mem_rounds  = satd_pkg::MEM_ROUNDS_RST;
  logic [satd_pkg::CFG_W-1:0]  disk_rounds = satd_pkg::DSK_ROUNDS_RST;

  slot_aging_tier_demoter_top #(.SLOTS(NSLOTS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .slot_i      (slot_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .slot_out_o  (slot_out_o),
    .status_o    (status_o),
    .to_memory_o (to_memory_o),
    .to_disk_o   (to_disk_o),
    .use_total_o (use_total_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // Mismatch reporting
  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic tier_result_t make_result(logic [satd_pkg::SLOT_W-1:0] slot,
                                               satd_pkg::status_e status,
                                               logic to_mem, logic to_disk,
                                               logic [satd_pkg::CNT_W-1:0] total,
                                               logic last);
    tier_result_t r;
    r.slot    = slot;
    r.status  = status;
    r.to_mem  = to_mem;
    r.to_disk = to_disk;
    r.total   = total;
    r.last    = last;
    return r;
  endfunction

  // Append one predicted result to the scoreboard
  task automatic queue_result(tier_result_t r);
    awaited_results = {awaited_results, r};
  endtask

  // Apply one accepted transaction to the slot table and queue its results
  task automatic apply_to_slot_table(slot_op_t op);
    int unsigned s;
    s = op.slot;
    case (op.act)
      satd_pkg::ACT_ADD: begin
        if (alloc_ptr >= NSLOTS) begin
          queue_result(make_result('0, satd_pkg::STAT_FULL, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          live[alloc_ptr]     = 1'b1;
          idle_age[alloc_ptr] = '0;
          queue_result(make_result(alloc_ptr[satd_pkg::SLOT_W-1:0], satd_pkg::STAT_OK,
                                   1'b0, 1'b0, '0, 1'b1));
          alloc_ptr = alloc_ptr + 1'b1;
        end
      end
      satd_pkg::ACT_USE: begin
        if (s < NSLOTS && live[s]) begin
          idle_age[s] = '0;
          if (use_tally != satd_pkg::CNT_MAX) use_tally = use_tally + 1'b1;
          queue_result(make_result(op.slot, satd_pkg::STAT_OK, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          queue_result(make_result(op.slot, satd_pkg::STAT_ABSENT, 1'b0, 1'b0, '0, 1'b1));
        end
      end
      satd_pkg::ACT_DEL: begin
        if (s < NSLOTS && live[s]) begin
          live[s] = 1'b0;
          queue_result(make_result(op.slot, satd_pkg::STAT_OK, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          queue_result(make_result(op.slot, satd_pkg::STAT_ABSENT, 1'b0, 1'b0, '0, 1'b1));
        end
      end
      default: begin
        // sweep: demote aged slots, then age every live slot
        for (int i = 0; i < NSLOTS; i++) begin
          if (live[i]) begin
            if (idle_age[i] >= mem_rounds) begin
              queue_result(make_result(i[satd_pkg::SLOT_W-1:0], satd_pkg::STAT_OK, 1'b1,
                                       idle_age[i] >= disk_rounds, '0, 1'b0));
            end
            if (idle_age[i] != satd_pkg::AGE_MAX) idle_age[i] = idle_age[i] + 1'b1;
          end
        end
        queue_result(make_result('0, satd_pkg::STAT_OK, 1'b0, 1'b0, use_tally, 1'b1));
        use_tally = '0;
      end
    endcase
  endtask

  // Monitor: check results, track register writes, predict accepted transactions
  always @(posedge clk_i) begin
    tier_result_t exp_r;
    slot_op_t     op;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result slot %0d status %0d",
                                  slot_out_o, status_o));
        end else begin
          exp_r = awaited_results.pop_front();
          if (slot_out_o !== exp_r.slot)
            note_mismatch($sformatf("slot_out %0d, want %0d", slot_out_o, exp_r.slot));
          if (status_o !== exp_r.status)
            note_mismatch($sformatf("status %0d, want %0d", status_o, exp_r.status));
          if (to_memory_o !== exp_r.to_mem)
            note_mismatch($sformatf("to_memory %0b, want %0b", to_memory_o, exp_r.to_mem));
          if (to_disk_o !== exp_r.to_disk)
            note_mismatch($sformatf("to_disk %0b, want %0b", to_disk_o, exp_r.to_disk));
          if (use_total_o !== exp_r.total)
            note_mismatch($sformatf("use_total %0d, want %0d", use_total_o, exp_r.total));
          if (last_o !== exp_r.last)
            note_mismatch($sformatf("last %0b, want %0b", last_o, exp_r.last));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == satd_pkg::CFG_MEMORY_ROUNDS) mem_rounds = cfg_data_i;
        else disk_rounds = cfg_data_i;
      end
      if (in_taken) begin
        op.act  = satd_pkg::action_e'(action_i);
        op.slot = slot_i;
        apply_to_slot_table(op);
      end
    end
  end

  // Receiver hold-off counter
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Driver: offer queued transactions, stall the result side
  always @(negedge clk_i) begin
    slot_op_t op;
    if (!in_valid_i || in_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle) begin
        op = pending_ops.pop_front();
        in_valid_i <= 1'b1;
        action_i   <= op.act;
        slot_i     <= op.slot;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < receiver_busy);
  end

  // Timeout
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("FAILURE");
    $finish;
  end

  task automatic queue_op(satd_pkg::action_e act, int unsigned slot);
    slot_op_t op;
    op.act  = act;
    op.slot = slot[satd_pkg::SLOT_W-1:0];
    pending_ops = {pending_ops, op};
  endtask

  // Random mix; deletes spare slot 0 so it stays live
  task automatic queue_random_ops(int unsigned n);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 20) queue_op(satd_pkg::ACT_ADD, $urandom);
      else if (r < 55)
        queue_op(satd_pkg::ACT_USE, $urandom_range(1) ? $urandom_range(15) : $urandom);
      else if (r < 65) queue_op(satd_pkg::ACT_DEL, $urandom_range(NSLOTS - 1, 1));
      else queue_op(satd_pkg::ACT_TICK, $urandom);
    end
  endtask

  // Block until every transaction is sent and every result has come back
  task automatic wait_quiet();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_ops.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(satd_pkg::cfg_idx_e idx, logic [satd_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(posedge clk_i);
    #1;
    sender_idle   = send_pct;
    receiver_busy = recv_pct;
  endtask

  // Stimulus sequence
  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      live[i]     = 1'b0;
      idle_age[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, absent slots, demote by default thresholds
    queue_op(satd_pkg::ACT_TICK, 0);
    queue_op(satd_pkg::ACT_USE, 0);
    queue_op(satd_pkg::ACT_DEL, 0);
    queue_op(satd_pkg::ACT_ADD, 31);
    queue_op(satd_pkg::ACT_ADD, 0);
    queue_op(satd_pkg::ACT_ADD, 17);
    queue_op(satd_pkg::ACT_USE, 31);
    queue_op(satd_pkg::ACT_TICK, 0);
    queue_op(satd_pkg::ACT_TICK, 0);
    queue_op(satd_pkg::ACT_TICK, 0);
    queue_op(satd_pkg::ACT_TICK, 0);
    queue_op(satd_pkg::ACT_TICK, 0);
    queue_op(satd_pkg::ACT_USE, 1);
    queue_op(satd_pkg::ACT_USE, 1);
    queue_op(satd_pkg::ACT_DEL, 2);
    queue_op(satd_pkg::ACT_DEL, 2);
    queue_op(satd_pkg::ACT_USE, 2);
    queue_op(satd_pkg::ACT_TICK, 0);
    queue_op(satd_pkg::ACT_ADD, 0);
    queue_op(satd_pkg::ACT_TICK, 31);
    wait_quiet();

    // Random, sender gaps; pause for a full drain halfway
    write_threshold(satd_pkg::CFG_MEMORY_ROUNDS, 8'd2);
    write_threshold(satd_pkg::CFG_DISK_ROUNDS, 8'd5);
    set_idling(54, 0);
    queue_random_ops(25);
    wait_quiet();
    queue_random_ops(25);
    wait_quiet();

    // Zero thresholds, receiver stalls with one long hold-off
    write_threshold(satd_pkg::CFG_MEMORY_ROUNDS, 8'd0);
    write_threshold(satd_pkg::CFG_DISK_ROUNDS, 8'd0);
    set_idling(0, 54);
    hold_left = HOLD_CYCLES;
    queue_random_ops(40);
    wait_quiet();

    // Light idling on both sides, full disk threshold
    write_threshold(satd_pkg::CFG_MEMORY_ROUNDS, 8'd3);
    write_threshold(satd_pkg::CFG_DISK_ROUNDS, 8'd255);
    set_idling(8, 8);
    queue_random_ops(60);
    wait_quiet();

    if (awaited_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
